/* rtl/sstf_pkg.sv */
// ----------------------------------------------------------------------------
// sstf_pkg: shared types and constants for the SSTF disk request scheduler
// Beat structs, register indexes, control groups and the sequencer states.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int TRACK_W = 16;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               batch_end;
  } in_item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic               last_served;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_TRACK_COUNT  = 2'd0,
    CFG_START_HEAD   = 2'd1,
    CFG_START_UPWARD = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_PICK = 2'd2
  } state_t;

  typedef struct packed {
    logic shift;
    logic clr_all;
  } cell_ctl_t;

  typedef struct packed {
    logic en;
    logic clr;
  } pick_ctl_t;

  typedef struct packed {
    logic               found;
    logic               moved;
    logic               go_up;
    logic [TRACK_W-1:0] track;
  } pick_res_t;

endpackage

/* rtl/sstf_cell.sv */
// ----------------------------------------------------------------------------
// sstf_cell: one slot of the request ring
// Holds one track and its valid bit; takes the neighbor's slot on shift.
// ----------------------------------------------------------------------------
module sstf_cell #(
  parameter int TRACK_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sstf_pkg::cell_ctl_t   ctl,
  input  logic [TRACK_BITS-1:0] d_track,
  input  logic                  d_valid,
  output logic [TRACK_BITS-1:0] q_track,
  output logic                  q_valid
);
  import sstf_pkg::*;

  logic [TRACK_BITS-1:0] track_r;
  logic                  valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr_all) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      track_r <= d_track;
    end
  end

  assign q_track = track_r;
  assign q_valid = valid_r;

endmodule

/* rtl/sstf_pick.sv */
// ----------------------------------------------------------------------------
// sstf_pick: nearest-track search at the ring tail
// Tracks the head hit, the nearest slot below and above over one pass,
// then resolves the winner with the direction tie break.
// ----------------------------------------------------------------------------
module sstf_pick #(
  parameter int IDX_W = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sstf_pkg::pick_ctl_t          ctl,
  input  logic [sstf_pkg::TRACK_W-1:0] tail_track,
  input  logic                         tail_valid,
  input  logic [IDX_W-1:0]             tail_idx,
  input  logic [sstf_pkg::TRACK_W-1:0] head,
  input  logic                         up,
  output sstf_pkg::pick_res_t          res,
  output logic [IDX_W-1:0]             sel_idx
);
  import sstf_pkg::*;

  logic               hit_f_r, hit_f_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               lo_f_r, lo_f_nxt;
  logic [TRACK_W-1:0] lo_t_r, lo_t_nxt;
  logic [IDX_W-1:0]   lo_idx_r, lo_idx_nxt;
  logic               hi_f_r, hi_f_nxt;
  logic [TRACK_W-1:0] hi_t_r, hi_t_nxt;
  logic [IDX_W-1:0]   hi_idx_r, hi_idx_nxt;
  logic [TRACK_W-1:0] dl, dh;
  logic               go_up;

  always_comb begin
    hit_f_nxt   = hit_f_r;
    hit_idx_nxt = hit_idx_r;
    lo_f_nxt    = lo_f_r;
    lo_t_nxt    = lo_t_r;
    lo_idx_nxt  = lo_idx_r;
    hi_f_nxt    = hi_f_r;
    hi_t_nxt    = hi_t_r;
    hi_idx_nxt  = hi_idx_r;
    if (ctl.clr) begin
      hit_f_nxt = 1'b0;
      lo_f_nxt  = 1'b0;
      hi_f_nxt  = 1'b0;
    end else if (ctl.en && tail_valid) begin
      if (tail_track == head) begin
        if (!hit_f_r) begin
          hit_f_nxt   = 1'b1;
          hit_idx_nxt = tail_idx;
        end
      end else if (tail_track < head) begin
        if (!lo_f_r || tail_track > lo_t_r) begin
          lo_f_nxt   = 1'b1;
          lo_t_nxt   = tail_track;
          lo_idx_nxt = tail_idx;
        end
      end else begin
        if (!hi_f_r || tail_track < hi_t_r) begin
          hi_f_nxt   = 1'b1;
          hi_t_nxt   = tail_track;
          hi_idx_nxt = tail_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_f_r <= 1'b0;
      lo_f_r  <= 1'b0;
      hi_f_r  <= 1'b0;
    end else begin
      hit_f_r <= hit_f_nxt;
      lo_f_r  <= lo_f_nxt;
      hi_f_r  <= hi_f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r <= hit_idx_nxt;
    lo_t_r    <= lo_t_nxt;
    lo_idx_r  <= lo_idx_nxt;
    hi_t_r    <= hi_t_nxt;
    hi_idx_r  <= hi_idx_nxt;
  end

  assign dl = head - lo_t_r;
  assign dh = hi_t_r - head;

  always_comb begin
    if (!lo_f_r) begin
      go_up = 1'b1;
    end else if (!hi_f_r) begin
      go_up = 1'b0;
    end else if (dh < dl) begin
      go_up = 1'b1;
    end else if (dl < dh) begin
      go_up = 1'b0;
    end else begin
      go_up = up;
    end
  end

  always_comb begin
    res.found = hit_f_r | lo_f_r | hi_f_r;
    res.moved = !hit_f_r;
    if (hit_f_r) begin
      res.go_up = up;
      res.track = head;
      sel_idx   = hit_idx_r;
    end else if (go_up) begin
      res.go_up = 1'b1;
      res.track = hi_t_r;
      sel_idx   = hi_idx_r;
    end else begin
      res.go_up = 1'b0;
      res.track = lo_t_r;
      sel_idx   = lo_idx_r;
    end
  end

endmodule

/* rtl/sstf_disk_request_scheduler_top.sv */
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_top: shortest-seek-time-first request scheduler
// Usage:
//   Input beats: drive start with in_item while busy is low. A track at or
//   above track_count, or beyond the ring capacity, is dropped. A beat with
//   batch_end closes the batch. After batch_end the block is busy and emits
//   one out_valid strobe per pending request in seek order, last_served set
//   on the final one. An empty batch gives no results and busy stays low.
//   For each result the requests circulate once around a ring of MAX_REQUESTS
//   cells past one compare unit at the tail, then the pick state resolves the
//   winner. Results are one-cycle strobes; the receiver cannot stall them.
//   Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready
//   follows !busy. Unknown indexes are ignored.
//   Reset empties the ring and sets track_count 65535, start_head 0 and
//   start_upward 1.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_top #(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  sstf_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output sstf_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [sstf_pkg::TRACK_W-1:0] cfg_data
);
  import sstf_pkg::*;

  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REQUESTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_REQUESTS);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [TRACK_W-1:0] head_r, head_nxt;
  logic               up_r, up_nxt;
  logic [IDX_W-1:0]   sel_idx_r, sel_idx_nxt;
  logic               clr_pend_r, clr_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic [TRACK_W-1:0] track_count_r;
  logic [TRACK_W-1:0] start_head_r;
  logic               start_upward_r;

  logic               accept;
  logic               ins_ok;
  logic [CNT_W-1:0]   count_after;
  logic               kill;
  cell_ctl_t          cell_ctl;
  pick_ctl_t          pick_ctl;
  pick_res_t          pick_res;
  logic [IDX_W-1:0]   pick_idx;

  logic [TRACK_BITS-1:0] cell_track [MAX_REQUESTS];
  logic                  cell_valid [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] ring_d_track;
  logic                  ring_d_valid;
  logic                  tail_valid;

  assign accept = start && !busy;
  assign ins_ok = ((32'(in_item.track) >> TRACK_BITS) == 32'd0) &&
                  (in_item.track < track_count_r) && (count_r < FULL_CNT);
  assign count_after = count_r + CNT_W'(ins_ok);
  assign kill = clr_pend_r && (cnt_r == sel_idx_r);
  assign tail_valid = cell_valid[MAX_REQUESTS-1] && !kill;

  always_comb begin
    if (state_r == ST_SCAN) begin
      ring_d_track = cell_track[MAX_REQUESTS-1];
      ring_d_valid = tail_valid;
    end else begin
      ring_d_track = TRACK_BITS'(in_item.track);
      ring_d_valid = 1'b1;
    end
  end

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    sstf_cell #(
      .TRACK_BITS(TRACK_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .d_track ((i == 0) ? ring_d_track : cell_track[(i == 0) ? 0 : i-1]),
      .d_valid ((i == 0) ? ring_d_valid : cell_valid[(i == 0) ? 0 : i-1]),
      .q_track (cell_track[i]),
      .q_valid (cell_valid[i])
    );
  end

  sstf_pick #(
    .IDX_W(IDX_W)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pick_ctl),
    .tail_track (TRACK_W'(cell_track[MAX_REQUESTS-1])),
    .tail_valid (tail_valid),
    .tail_idx   (cnt_r),
    .head       (head_r),
    .up         (up_r),
    .res        (pick_res),
    .sel_idx    (pick_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.batch_end && (count_after != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!pick_res.found || (rem_r == CNT_W'(1))) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy             = (state_r != ST_IDLE);
    cell_ctl.shift   = 1'b0;
    cell_ctl.clr_all = 1'b0;
    pick_ctl.en      = 1'b0;
    pick_ctl.clr     = 1'b1;
    cnt_nxt          = cnt_r;
    count_nxt        = count_r;
    rem_nxt          = rem_r;
    head_nxt         = head_r;
    up_nxt           = up_r;
    sel_idx_nxt      = sel_idx_r;
    clr_pend_nxt     = clr_pend_r;
    out_valid_nxt    = 1'b0;
    out_nxt          = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cell_ctl.shift = ins_ok;
          count_nxt      = count_after;
          if (in_item.batch_end) begin
            head_nxt     = start_head_r;
            up_nxt       = start_upward_r;
            rem_nxt      = count_after;
            cnt_nxt      = '0;
            clr_pend_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        cell_ctl.shift = 1'b1;
        pick_ctl.en    = 1'b1;
        pick_ctl.clr   = 1'b0;
        cnt_nxt        = (cnt_r == LAST_IDX) ? '0 : cnt_r + IDX_W'(1);
      end
      ST_PICK: begin
        if (pick_res.found) begin
          out_valid_nxt        = 1'b1;
          out_nxt.served_track = pick_res.track;
          out_nxt.last_served  = (rem_r == CNT_W'(1));
          rem_nxt              = rem_r - CNT_W'(1);
          sel_idx_nxt          = pick_idx;
          clr_pend_nxt         = 1'b1;
          if (pick_res.moved) begin
            head_nxt = pick_res.track;
            up_nxt   = pick_res.go_up;
          end
        end
        if (!pick_res.found || (rem_r == CNT_W'(1))) begin
          cell_ctl.clr_all = 1'b1;
          count_nxt        = '0;
        end
      end
      default: begin
        cell_ctl.clr_all = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      head_r      <= '0;
      up_r        <= 1'b1;
      sel_idx_r   <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      head_r      <= head_nxt;
      up_r        <= up_nxt;
      sel_idx_r   <= sel_idx_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_count_r  <= 16'hFFFF;
      start_head_r   <= '0;
      start_upward_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRACK_COUNT:  track_count_r  <= cfg_data;
        CFG_START_HEAD:   start_head_r   <= cfg_data;
        CFG_START_UPWARD: start_upward_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_strobe_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_PICK))
    else $error("result strobe without a pick cycle");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last_served) |-> (state_r == ST_IDLE && count_r == '0))
    else $error("final result while batch still active");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= FULL_CNT) && (rem_r <= count_r || state_r == ST_IDLE))
    else $error("request count out of range");
`endif

endmodule

/* dv/sstf_disk_request_scheduler_top_test.sv */
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_top_test: seek order check for the SSTF scheduler
// Feeds request batches through the start/busy port under several register
// settings, predicts the shortest-seek-time-first service order of every
// batch and compares each out_valid strobe with the oldest predicted beat.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_top_test;
  import sstf_pkg::*;

  localparam int MAX_REQ = 32;
  localparam int ITEM_GOAL = 500;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [TRACK_W-1:0] cfg_data = '0;

  in_item_t request_q[$];
  out_item_t seek_order_q[$];
  out_item_t want;

  logic [TRACK_W-1:0] reg_tracks = 16'hFFFF;
  logic [TRACK_W-1:0] reg_head = '0;
  logic reg_up = 1'b1;

  logic [TRACK_W-1:0] held_trk[MAX_REQ];
  bit held_valid[MAX_REQ];
  int held_cnt = 0;
  logic [TRACK_W-1:0] head_pos = '0;
  bit heading_up = 1'b1;

  int mismatch_cnt = 0;
  int cycle = 0;
  int gap_left = 0;
  bit took;
  bit burst = 1'b0;

  sstf_disk_request_scheduler_top #(
    .MAX_REQUESTS(MAX_REQ),
    .TRACK_BITS(TRACK_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("cycle %0d: mismatch: %s", cycle, what);
    mismatch_cnt++;
  endtask

  function automatic void sstf_order(input in_item_t beat);
    out_item_t res;
    int left, hit, lo, hi, pick;
    logic [TRACK_W-1:0] dl, dh;
    bit go_up;
    if (beat.track < reg_tracks && held_cnt < MAX_REQ) begin
      for (int i = 0; i < MAX_REQ; i++) begin
        if (!held_valid[i]) begin
          held_trk[i] = beat.track;
          held_valid[i] = 1'b1;
          held_cnt++;
          break;
        end
      end
    end
    if (!beat.batch_end) return;
    head_pos = reg_head;
    heading_up = reg_up;
    left = held_cnt;
    while (left > 0) begin
      hit = -1;
      lo = -1;
      hi = -1;
      for (int i = 0; i < MAX_REQ; i++) begin
        if (held_valid[i]) begin
          if (held_trk[i] == head_pos) begin
            if (hit < 0) hit = i;
          end else if (held_trk[i] < head_pos) begin
            if (lo < 0 || held_trk[i] > held_trk[lo]) lo = i;
          end else begin
            if (hi < 0 || held_trk[i] < held_trk[hi]) hi = i;
          end
        end
      end
      if (hit >= 0) begin
        pick = hit;
      end else if (lo < 0 && hi < 0) begin
        break;
      end else begin
        if (lo < 0) begin
          go_up = 1'b1;
        end else if (hi < 0) begin
          go_up = 1'b0;
        end else begin
          dl = head_pos - held_trk[lo];
          dh = held_trk[hi] - head_pos;
          go_up = (dh < dl) ? 1'b1 : (dl < dh) ? 1'b0 : heading_up;
        end
        heading_up = go_up;
        pick = go_up ? hi : lo;
        head_pos = held_trk[pick];
      end
      held_valid[pick] = 1'b0;
      left--;
      res.served_track = held_trk[pick];
      res.last_served = (left == 0);
      seek_order_q.push_back(res);
    end
    for (int i = 0; i < MAX_REQ; i++) held_valid[i] = 1'b0;
    held_cnt = 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        sstf_order(in_item);
        gap_left = draw_gap();
      end
      if (!start || took) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_item <= request_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (seek_order_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat, track %0d", out_item.served_track));
      end else begin
        want = seek_order_q.pop_front();
        if (out_item.served_track !== want.served_track)
          flag_mismatch($sformatf("served_track %0d, want %0d",
                                  out_item.served_track, want.served_track));
        if (out_item.last_served !== want.last_served)
          flag_mismatch($sformatf("last_served %0b, want %0b (track %0d)",
                                  out_item.last_served, want.last_served,
                                  want.served_track));
      end
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [TRACK_W-1:0] data);
    int pause;
    pause = draw_gap();
    repeat (pause + 1) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TRACK_COUNT: reg_tracks = data;
      CFG_START_HEAD: reg_head = data;
      CFG_START_UPWARD: reg_up = data[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (request_q.size() != 0 || start || seek_order_q.size() != 0);
    repeat (MAX_REQ + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_req(input logic [TRACK_W-1:0] trk, input logic last);
    in_item_t beat;
    beat.track = trk;
    beat.batch_end = last;
    request_q.push_back(beat);
  endtask

  function automatic logic [TRACK_W-1:0] pick_track();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4 && reg_tracks > 0) return TRACK_W'($urandom_range(0, reg_tracks - 1));
    if (mode < 7) return TRACK_W'(reg_head + $urandom_range(0, 16) - 8);
    if (mode == 7) return TRACK_W'($urandom_range(reg_tracks, 16'hFFFF));
    return TRACK_W'($urandom_range(0, 16'hFFFF));
  endfunction

  initial begin
    int sent, nbatch, len, sel;
    logic [TRACK_W-1:0] val;
    for (int i = 0; i < MAX_REQ; i++) begin
      held_trk[i] = '0;
      held_valid[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_req(16'h0000, 1'b0);
    add_req(16'hFFFF, 1'b0);
    add_req(16'hFFFE, 1'b0);
    add_req(16'h0000, 1'b0);
    add_req(16'd5, 1'b1);
    add_req(16'hFFFF, 1'b1);
    wait_drained();

    write_reg(CFG_TRACK_COUNT, 16'd100);
    write_reg(CFG_START_HEAD, 16'd50);
    write_reg(CFG_START_UPWARD, 16'hFFFE);
    write_reg(CFG_UNUSED, 16'h0001);
    @(negedge clk);
    add_req(16'd40, 1'b0);
    add_req(16'd60, 1'b0);
    add_req(16'd30, 1'b0);
    add_req(16'd100, 1'b0);
    add_req(16'd50, 1'b1);
    add_req(16'd20, 1'b0);
    add_req(16'd10, 1'b1);
    wait_drained();

    write_reg(CFG_START_UPWARD, 16'h0001);
    @(negedge clk);
    add_req(16'd10, 1'b0);
    add_req(16'd20, 1'b1);
    add_req(16'd45, 1'b0);
    add_req(16'd55, 1'b1);
    wait_drained();

    write_reg(CFG_TRACK_COUNT, 16'd1);
    write_reg(CFG_START_HEAD, 16'd65534);
    @(negedge clk);
    add_req(16'd0, 1'b0);
    add_req(16'd1, 1'b0);
    add_req(16'd0, 1'b1);
    wait_drained();

    write_reg(CFG_TRACK_COUNT, 16'd0);
    @(negedge clk);
    add_req(16'd0, 1'b1);
    wait_drained();

    sent = 0;
    while (sent < ITEM_GOAL) begin
      burst = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 7);
      val = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'd1 : (sel == 2) ? 16'd0 :
            (sel < 5) ? 16'($urandom_range(2, 40)) : 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 2) != 0) write_reg(CFG_TRACK_COUNT, val);
      sel = $urandom_range(0, 5);
      val = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd65534 :
            (sel == 2 || reg_tracks == 0) ? 16'($urandom_range(0, 65534)) :
            16'($urandom_range(0, reg_tracks - 1));
      if ($urandom_range(0, 2) != 0) write_reg(CFG_START_HEAD, val);
      if ($urandom_range(0, 2) != 0) write_reg(CFG_START_UPWARD, 16'($urandom));
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 16'($urandom));
      @(negedge clk);
      nbatch = $urandom_range(1, 4);
      repeat (nbatch) begin
        sel = $urandom_range(0, 9);
        len = (sel == 0) ? $urandom_range(30, 40) : (sel == 1) ? 1 : $urandom_range(2, 10);
        for (int k = 0; k < len; k++) add_req(pick_track(), k == len - 1);
        sent += len;
      end
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
